// ----- rtl/adc_voltmeter_seven_segment_scan_assert.svh -----
// assertion macros for the voltmeter scan block
// uses clk and rst_n of the including module; no other dependencies
`ifndef ADC_VOLTMETER_SEVEN_SEGMENT_SCAN_ASSERT_SVH
`define ADC_VOLTMETER_SEVEN_SEGMENT_SCAN_ASSERT_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define AVSS_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("avss same-cycle check failed");
// consequent must hold in the cycle after the antecedent
`define AVSS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("avss next-cycle check failed");
`else
`define AVSS_ASSERT_SAME(label, cond, prop)
`define AVSS_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// ----- rtl/avss_pkg.sv -----
// shared types, constants and the segment decode for the voltmeter scan
// no dependencies
`default_nettype none

package avss_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned POS_W    = 2;

    localparam logic [SAMPLE_W-1:0] HYST_RESET = 10'd3;
    localparam logic [8:0]          VOLT_SCALE = 9'd500;
    localparam logic [SAMPLE_W-1:0] ADC_MAX    = 10'd1023;
    localparam logic [SAMPLE_W-1:0] THOUSAND   = 10'd1000;

    // scan positions, thousands first
    localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd0;
    localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd1;
    localparam logic [POS_W-1:0] POS_UNITS     = 2'd3;

    // active-low select pattern of the units digit
    localparam logic [3:0] SEL_UNITS_N    = 4'b0111;
    localparam logic [3:0] SEL_HUNDREDS_N = 4'b1101;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] volt;
        logic                press;
    } scaled_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                raw;
    } disp_t;

    // common-anode patterns, decimal segment off
    function automatic logic [7:0] seg_code(input logic [DIGIT_W-1:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/avss_scale.sv -----
// input register and voltage scaling stage: floor(sample*500/1023)
// depends on avss_pkg
`default_nettype none

module avss_scale
    import avss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [SAMPLE_W-1:0] s_sample,
    input  wire logic                s_press,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output scaled_t                  m_data
);

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                in_press_reg;
    logic                out_valid_reg;
    scaled_t             out_data_reg;

    logic                advance;
    logic [18:0]         prod;
    logic [19:0]         sum;
    logic [SAMPLE_W-1:0] est;
    logic [18:0]         back;
    logic [18:0]         rem;
    logic [SAMPLE_W-1:0] volt;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // divide by 1023 as x/1024 * (1 + 1/1024), low by at most one, then fix up
    always_comb
    begin
        prod = 19'(in_sample_reg) * 19'(VOLT_SCALE);
        sum  = 20'(prod) + 20'(prod >> 10);
        est  = sum[19:10];
        back = (19'(est) << 10) - 19'(est);
        rem  = prod - back;
        if (rem >= 19'(ADC_MAX))
            volt = est + 10'd1;
        else
            volt = est;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_valid && s_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            in_sample_reg <= s_sample;
            in_press_reg  <= s_press;
        end
        if (advance)
        begin
            out_data_reg.sample <= in_sample_reg;
            out_data_reg.volt   <= volt;
            out_data_reg.press  <= in_press_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/avss_update.sv -----
// mode toggle and hysteresis stage; holds the mode and the shown value
// depends on avss_pkg
`default_nettype none

module avss_update
    import avss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [SAMPLE_W-1:0] hyst_step,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire scaled_t             s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output disp_t                    m_data
);

    logic                mode_flag_reg;
    logic                mode_flag_next;
    logic [SAMPLE_W-1:0] shown_value_reg;
    logic [SAMPLE_W-1:0] shown_value_next;
    logic                out_valid_reg;
    disp_t               out_data_reg;

    logic                take;
    logic [SAMPLE_W-1:0] fresh;
    logic [SAMPLE_W-1:0] diff;

    assign s_ready = !out_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb
    begin
        mode_flag_next = mode_flag_reg ^ s_data.press;
        fresh = mode_flag_next ? s_data.sample : s_data.volt;
        if (fresh >= shown_value_reg)
            diff = fresh - shown_value_reg;
        else
            diff = shown_value_reg - fresh;
        if (diff >= hyst_step)
            shown_value_next = fresh;
        else
            shown_value_next = shown_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_flag_reg   <= 1'b0;
            shown_value_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_flag_reg   <= mode_flag_next;
                shown_value_reg <= shown_value_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg.value <= shown_value_next;
            out_data_reg.raw   <= mode_flag_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/avss_scan.sv -----
// decimal split and four-beat digit scan with the output register
// depends on avss_pkg
`default_nettype none

module avss_scan
    import avss_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire disp_t  s_data,
    output logic        m_valid,
    input  wire logic   m_ready,
    output logic [7:0]  m_segments,
    output logic [3:0]  m_select_n,
    output logic        m_point_n,
    output logic        m_raw,
    output logic        m_last
);

    logic                     busy_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [DIGIT_W-1:0]       digit_reg [4];
    logic                     raw_reg;

    logic                     out_valid_reg;
    logic [7:0]               seg_reg;
    logic [3:0]               sel_reg;
    logic                     point_reg;
    logic                     out_raw_reg;
    logic                     last_reg;

    logic                     emit;
    logic                     load;
    logic                     th;
    logic [SAMPLE_W-1:0]      r1;
    logic [15:0]              hq;
    logic [DIGIT_W-1:0]       hd;
    logic [SAMPLE_W-1:0]      r2w;
    logic [6:0]               r2;
    logic [14:0]              tq;
    logic [DIGIT_W-1:0]       td;
    logic [6:0]               ud;

    assign emit    = busy_reg && (!out_valid_reg || m_ready);
    assign s_ready = !busy_reg || (emit && pos_reg == POS_UNITS);
    assign load    = s_valid && s_ready;

    assign m_valid    = out_valid_reg;
    assign m_segments = seg_reg;
    assign m_select_n = sel_reg;
    assign m_point_n  = point_reg;
    assign m_raw      = out_raw_reg;
    assign m_last     = last_reg;

    // reciprocal multiplies: *41>>12 is exact /100 below 1000, *205>>11 is /10 below 100
    always_comb
    begin
        th  = s_data.value >= THOUSAND;
        r1  = th ? s_data.value - THOUSAND : s_data.value;
        hq  = 16'(r1) * 16'd41;
        hd  = hq[15:12];
        r2w = r1 - 10'(hd) * 10'd100;
        r2  = r2w[6:0];
        tq  = 15'(r2) * 15'd205;
        td  = tq[14:11];
        ud  = r2 - 7'(td) * 7'd10;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_THOUSANDS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= POS_THOUSANDS;
            end
            else if (emit)
            begin
                pos_reg <= pos_reg + 2'd1;
                if (pos_reg == POS_UNITS)
                    busy_reg <= 1'b0;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digit_reg[0] <= {3'd0, th};
            digit_reg[1] <= hd;
            digit_reg[2] <= td;
            digit_reg[3] <= ud[3:0];
            raw_reg      <= s_data.raw;
        end
        if (emit)
        begin
            seg_reg     <= seg_code(digit_reg[pos_reg]);
            sel_reg     <= ~(4'b0001 << pos_reg);
            point_reg   <= !(!raw_reg && pos_reg == POS_HUNDREDS);
            out_raw_reg <= raw_reg;
            last_reg    <= pos_reg == POS_UNITS;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/adc_voltmeter_seven_segment_scan.sv -----
// Four-digit seven-segment voltmeter scan. Each accepted converter sample (with an optional
// mode-button toggle applied first) is scaled to hundredths of a volt or passed raw, filtered
// by the hysteresis step, split into four decimal digits and delivered as four output
// transactions, thousands digit first, tlast on the units digit. The path is a register
// pipeline (input register, scaled-value register, mode and hysteresis register, digit-scan
// register) followed by the output register; an accepted item passes through these registers
// in that order before its digits reach the output. The four-beat digit scan limits the
// sustained rate, and a new sample is accepted while earlier ones are still in flight. The
// hysteresis step is written on the cfg channel, which is always ready; write it only while
// no transaction is in flight.
// depends on avss_pkg, avss_scale, avss_update, avss_scan and the assertion macro header
`default_nettype none

`include "adc_voltmeter_seven_segment_scan_assert.svh"

module adc_voltmeter_seven_segment_scan
    import avss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data,       // hysteresis_step
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [9:0] adc_sample, [15:10] zero
    input  wire logic        s_axis_tuser,   // [0] mode_press
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,        // [7:0] segments, [11:8] digit_select_n,
                                             // [12] point_n, [15:13] zero
    output logic             m_axis_tuser,   // [0] raw_mode
    output logic             m_axis_tlast    // units digit
);

    logic [SAMPLE_W-1:0] hyst_step_reg;

    logic    scaled_valid;
    logic    scaled_ready;
    scaled_t scaled_data;
    logic    disp_valid;
    logic    disp_ready;
    disp_t   disp_data;

    logic [7:0] segments;
    logic [3:0] digit_select_n;
    logic       point_n;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hyst_step_reg <= HYST_RESET;
        else if (cfg_valid && cfg_ready)
            hyst_step_reg <= cfg_data;
    end

    avss_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_sample (s_axis_tdata[SAMPLE_W-1:0]),
        .s_press  (s_axis_tuser),
        .m_valid  (scaled_valid),
        .m_ready  (scaled_ready),
        .m_data   (scaled_data)
    );

    avss_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .hyst_step (hyst_step_reg),
        .s_valid   (scaled_valid),
        .s_ready   (scaled_ready),
        .s_data    (scaled_data),
        .m_valid   (disp_valid),
        .m_ready   (disp_ready),
        .m_data    (disp_data)
    );

    avss_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (disp_valid),
        .s_ready    (disp_ready),
        .s_data     (disp_data),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_segments (segments),
        .m_select_n (digit_select_n),
        .m_point_n  (point_n),
        .m_raw      (m_axis_tuser),
        .m_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, point_n, digit_select_n, segments};

    // the run always closes on the units digit
    `AVSS_ASSERT_SAME(a_last_is_units, m_axis_tvalid && m_axis_tlast, digit_select_n == SEL_UNITS_N)
    // point only in voltage mode on the hundreds digit
    `AVSS_ASSERT_SAME(a_point_place, m_axis_tvalid && !point_n, !m_axis_tuser && digit_select_n == SEL_HUNDREDS_N)
    // a run is not broken up: the next digit follows right after a taken one
    `AVSS_ASSERT_NEXT(a_run_unbroken, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule

`default_nettype wire
